>>> design/srq_pkg.sv
package srq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_FIFO  = 2'd0,
		MODE_PRIO  = 2'd1,
		MODE_BURST = 2'd2,
		MODE_LIFO  = 2'd3
	} order_mode_t;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [7:0]  prio;
		logic [15:0] burst;
	} entry_t;

	// compare request broadcast to every cell on the accept cycle
	typedef struct packed {
		cmd_t        cmd;
		order_mode_t mode;
		entry_t      key;
	} probe_t;

	// shift request broadcast on the update cycle
	typedef struct packed {
		logic ins;
		logic del;
	} shift_t;

endpackage

>>> design/srq_cell.sv
module srq_cell (
	input  logic            clk,
	input  logic            capture,
	input  srq_pkg::probe_t probe,
	input  logic            occupied,
	input  logic            at_tail,
	input  srq_pkg::shift_t shift,
	input  logic            before_in,
	input  srq_pkg::entry_t left,
	input  srq_pkg::entry_t right,
	input  srq_pkg::entry_t fresh,
	output srq_pkg::entry_t entry,
	output logic            before_out
);

	srq_pkg::entry_t entry_q;
	logic            hit_q;
	logic            cond;

	always_comb begin
		if (probe.cmd == srq_pkg::CMD_DELETE) begin
			cond = (entry_q.id == probe.key.id);
		end else begin
			case (probe.mode)
				srq_pkg::MODE_PRIO:  cond = (entry_q.prio <= probe.key.prio);
				srq_pkg::MODE_BURST: cond = (entry_q.burst >= probe.key.burst);
				srq_pkg::MODE_LIFO:  cond = 1'b1;
				default:             cond = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			hit_q <= occupied & cond;
		end
	end

	// earlier hit: insert shifts down, delete shifts up
	always_ff @(posedge clk) begin
		if (shift.ins) begin
			if (before_in) begin
				entry_q <= left;
			end else if (hit_q || at_tail) begin
				entry_q <= fresh;
			end
		end else if (shift.del && (before_in || hit_q)) begin
			entry_q <= right;
		end
	end

	assign before_out = before_in | hit_q;
	assign entry      = entry_q;

endmodule

>>> design/sorted_ready_queue.sv
// sorted_ready_queue: bounded task ready queue built as a row of slot cells.
// The result strobe (done) follows an accepted start once every cell has
// compared and captured its hit and the row has then shifted.
// busy rises after each accept and drops once the row has shifted; start is ignored while busy is high.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (arst_n low, asynchronous): queue empty, order_mode = fifo, idle.
module sorted_ready_queue (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_wen,
	input  logic [1:0]  cfg_wdata,
	// command
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  task_id,
	input  logic [7:0]  task_priority,
	input  logic [15:0] task_burst,
	// result
	output logic        done,
	output logic [1:0]  status,
	output logic [4:0]  entry_count,
	output logic        head_valid,
	output logic [7:0]  head_task_id,
	output logic [7:0]  head_priority,
	output logic [15:0] head_burst
);

	localparam int DEPTH = srq_pkg::QUEUE_DEPTH;
	localparam int CW    = srq_pkg::CNT_W;

	srq_pkg::order_mode_t mode_q;
	logic                 busy_q;
	logic                 done_q;
	srq_pkg::status_t     status_q;
	logic [CW-1:0]        count_q;

	srq_pkg::cmd_t        cmd_s1;
	srq_pkg::entry_t      new_s1;

	srq_pkg::probe_t      probe;
	srq_pkg::shift_t      shift;
	logic                 accept;
	logic                 full;
	logic                 found;

	srq_pkg::entry_t      slot   [DEPTH];
	logic [DEPTH:0]       hit_chain;

	assign accept = start & ~busy_q;

	// compare key comes straight from the ports on the accept cycle
	assign probe.cmd       = srq_pkg::cmd_t'(cmd);
	assign probe.mode      = mode_q;
	assign probe.key.id    = task_id;
	assign probe.key.prio  = task_priority;
	assign probe.key.burst = task_burst;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= srq_pkg::MODE_FIFO;
		end else if (cfg_wen) begin
			mode_q <= srq_pkg::order_mode_t'(cfg_wdata);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1       <= srq_pkg::cmd_t'(cmd);
			new_s1.id    <= task_id;
			new_s1.prio  <= task_priority;
			new_s1.burst <= task_burst;
		end
	end

	// update cycle: full and found are judged on the count/hits from the
	// compare cycle; nothing else touches the row in between
	assign full  = (count_q == CW'(DEPTH));
	assign found = hit_chain[DEPTH];
	assign shift.ins = busy_q & (cmd_s1 == srq_pkg::CMD_INSERT) & ~full;
	assign shift.del = busy_q & (cmd_s1 == srq_pkg::CMD_DELETE) & found;

	// slot 0 is the head; hit flags ripple toward the tail so each cell
	// knows whether an earlier slot is the insert/delete point
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		srq_pkg::entry_t left_e;
		srq_pkg::entry_t right_e;

		if (i == 0) begin : g_first
			assign left_e = new_s1;
		end else begin : g_mid
			assign left_e = slot[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = new_s1;
		end else begin : g_inner
			assign right_e = slot[i+1];
		end

		srq_cell u_cell (
			.clk        (clk),
			.capture    (accept),
			.probe      (probe),
			.occupied   (count_q > CW'(i)),
			.at_tail    (count_q == CW'(i)),
			.shift      (shift),
			.before_in  (hit_chain[i]),
			.left       (left_e),
			.right      (right_e),
			.fresh      (new_s1),
			.entry      (slot[i]),
			.before_out (hit_chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= srq_pkg::ST_DONE;
			count_q  <= '0;
		end else begin
			done_q <= busy_q;
			if (accept) begin
				busy_q <= 1'b1;
			end else if (busy_q) begin
				busy_q <= 1'b0;
				if (cmd_s1 == srq_pkg::CMD_INSERT) begin
					if (full) begin
						status_q <= srq_pkg::ST_FULL;
					end else begin
						status_q <= srq_pkg::ST_DONE;
						count_q  <= count_q + CW'(1);
					end
				end else begin
					if (found) begin
						status_q <= srq_pkg::ST_DONE;
						count_q  <= count_q - CW'(1);
					end else begin
						status_q <= srq_pkg::ST_NOT_FOUND;
					end
				end
			end
		end
	end

	// result word: head is read from slot 0 after the shift
	assign busy          = busy_q;
	assign done          = done_q;
	assign status        = status_q;
	assign entry_count   = 5'(count_q);
	assign head_valid    = (count_q != '0);
	assign head_task_id  = head_valid ? slot[0].id    : '0;
	assign head_priority = head_valid ? slot[0].prio  : '0;
	assign head_burst    = head_valid ? slot[0].burst : '0;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##1 done_q)
		else $error("result strobe missing two cycles after accept");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("occupancy above queue depth");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && status_q == srq_pkg::ST_FULL |-> count_q == CW'(DEPTH))
		else $error("full status with room left");

	a_one_shift: assert property (@(posedge clk) disable iff (!arst_n)
		!(shift.ins && shift.del))
		else $error("insert and delete shift together");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result shown while busy");

endmodule

>>> test/tb_sorted_ready_queue.sv
module tb_sorted_ready_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import srq_pkg::*;

	// one report per word: status, count after the word, head entry
	typedef struct packed {
		status_t     status;
		logic [4:0]  count;
		logic        head_valid;
		entry_t      head;
	} report_t;

	// directed plan: register writes and words, a word row may repeat with id+1
	typedef enum bit {ROW_CFG, ROW_WORD} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		order_mode_t mode;
		cmd_t        op;
		entry_t      key;
		int unsigned reps;
		bit          typed;   // report typed in below instead of predicted
		report_t     want;
	} row_t;

	localparam int NUM_ROWS   = 22;
	localparam int NUM_PHASES = 8;
	localparam int PHASE_LEN  = 228;

	// clock, reset and block inputs, all known from time zero
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wen       = 1'b0;
	logic [1:0]  cfg_wdata     = '0;
	logic        start         = 1'b0;
	logic        cmd           = 1'b0;
	logic [7:0]  task_id       = '0;
	logic [7:0]  task_priority = '0;
	logic [15:0] task_burst    = '0;

	logic        busy;
	logic        done;
	logic [1:0]  status;
	logic [4:0]  entry_count;
	logic        head_valid;
	logic [7:0]  head_task_id;
	logic [7:0]  head_priority;
	logic [15:0] head_burst;

	// shadow copy of the queue: index 0 is the head
	entry_t      shadow_slots[$];
	order_mode_t shadow_mode = MODE_FIFO;

	// reports owed by the block, oldest first
	report_t     reports_in_flight[$];

	bit          no_idle = 1'b0;
	int unsigned mismatches = 0;
	int unsigned words_sent = 0;
	int unsigned reports_seen = 0;
	int unsigned full_drops = 0;
	int unsigned delete_misses = 0;
	int unsigned mode_writes[4] = '{0, 0, 0, 0};

	// Directed words. Typed reports only where the queue is trivially known:
	// empty queue, the extreme entries, and the full / not-found codes.
	// Rows in between (ties, duplicate ids, mode changes with entries
	// already queued) are left to the shadow queue.
	row_t plan [0:NUM_ROWS-1] = '{
		'{ROW_CFG,  MODE_FIFO,  CMD_INSERT, '0, 0, 1'b0, '0},
		// delete on an empty queue
		'{ROW_WORD, MODE_FIFO,  CMD_DELETE, '{8'h5A, 8'h00, 16'h0000}, 1, 1'b1,
			'{ST_NOT_FOUND, 5'd0, 1'b0, '0}},
		// extremes in and out; delete ignores priority and burst
		'{ROW_WORD, MODE_FIFO,  CMD_INSERT, '{8'hFF, 8'hFF, 16'hFFFF}, 1, 1'b1,
			'{ST_DONE, 5'd1, 1'b1, '{8'hFF, 8'hFF, 16'hFFFF}}},
		'{ROW_WORD, MODE_FIFO,  CMD_INSERT, '{8'h00, 8'h00, 16'h0000}, 1, 1'b1,
			'{ST_DONE, 5'd2, 1'b1, '{8'hFF, 8'hFF, 16'hFFFF}}},
		'{ROW_WORD, MODE_FIFO,  CMD_DELETE, '{8'hFF, 8'hAA, 16'h5555}, 1, 1'b1,
			'{ST_DONE, 5'd1, 1'b1, '{8'h00, 8'h00, 16'h0000}}},
		'{ROW_WORD, MODE_FIFO,  CMD_DELETE, '{8'h00, 8'h55, 16'hAAAA}, 1, 1'b1,
			'{ST_DONE, 5'd0, 1'b0, '0}},
		// priority order: equal priority goes ahead, duplicate id nearest head
		'{ROW_CFG,  MODE_PRIO,  CMD_INSERT, '0, 0, 1'b0, '0},
		'{ROW_WORD, MODE_PRIO,  CMD_INSERT, '{8'h01, 8'h50, 16'h0007}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_PRIO,  CMD_INSERT, '{8'h02, 8'h80, 16'h0009}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_PRIO,  CMD_INSERT, '{8'h03, 8'h80, 16'h0005}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_PRIO,  CMD_INSERT, '{8'h02, 8'hC8, 16'h0001}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_PRIO,  CMD_DELETE, '{8'h02, 8'h00, 16'h0000}, 1, 1'b0, '0},
		// burst order on a queue not sorted by burst, equal burst goes ahead
		'{ROW_CFG,  MODE_BURST, CMD_INSERT, '0, 0, 1'b0, '0},
		'{ROW_WORD, MODE_BURST, CMD_INSERT, '{8'h06, 8'h10, 16'h012C}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_BURST, CMD_INSERT, '{8'h07, 8'h20, 16'h012C}, 1, 1'b0, '0},
		'{ROW_WORD, MODE_BURST, CMD_INSERT, '{8'h08, 8'h30, 16'h0000}, 1, 1'b0, '0},
		// lifo puts id 9 at the head; it stays there through the fill
		'{ROW_CFG,  MODE_LIFO,  CMD_INSERT, '0, 0, 1'b0, '0},
		'{ROW_WORD, MODE_LIFO,  CMD_INSERT, '{8'h09, 8'h3C, 16'h0BAD}, 1, 1'b0, '0},
		'{ROW_CFG,  MODE_FIFO,  CMD_INSERT, '0, 0, 1'b0, '0},
		'{ROW_WORD, MODE_FIFO,  CMD_INSERT, '{8'h10, 8'h40, 16'h1000}, 9, 1'b0, '0},
		// full queue: insert dropped, then a delete that finds nothing
		'{ROW_WORD, MODE_FIFO,  CMD_INSERT, '{8'h77, 8'h01, 16'h0001}, 1, 1'b1,
			'{ST_FULL, 5'd16, 1'b1, '{8'h09, 8'h3C, 16'h0BAD}}},
		'{ROW_WORD, MODE_FIFO,  CMD_DELETE, '{8'h99, 8'h00, 16'h0000}, 1, 1'b1,
			'{ST_NOT_FOUND, 5'd16, 1'b1, '{8'h09, 8'h3C, 16'h0BAD}}}
	};

	sorted_ready_queue i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.start         (start),
		.busy          (busy),
		.cmd           (cmd),
		.task_id       (task_id),
		.task_priority (task_priority),
		.task_burst    (task_burst),
		.done          (done),
		.status        (status),
		.entry_count   (entry_count),
		.head_valid    (head_valid),
		.head_task_id  (head_task_id),
		.head_priority (head_priority),
		.head_burst    (head_burst)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Apply one word to the shadow queue and return the report it yields.
	// Insert: full queue drops it; otherwise the slot depends on the mode.
	// Delete: first id match from the head; priority and burst unused.
	function automatic report_t run_queue_op(cmd_t op, entry_t e);
		report_t r;
		int      pos;
		r = '0;
		r.status = ST_DONE;
		if (op == CMD_INSERT) begin
			if (shadow_slots.size() >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				pos = 0;
				case (shadow_mode)
					MODE_PRIO: begin
						while (pos < shadow_slots.size() && shadow_slots[pos].prio > e.prio)
							pos++;
					end
					MODE_BURST: begin
						while (pos < shadow_slots.size() && shadow_slots[pos].burst < e.burst)
							pos++;
					end
					MODE_LIFO: pos = 0;
					default:   pos = shadow_slots.size();
				endcase
				shadow_slots.insert(pos, e);
			end
		end else begin
			pos = 0;
			while (pos < shadow_slots.size() && shadow_slots[pos].id != e.id)
				pos++;
			if (pos == shadow_slots.size()) begin
				r.status = ST_NOT_FOUND;
				delete_misses++;
			end else begin
				shadow_slots.delete(pos);
			end
		end
		r.count = 5'(shadow_slots.size());
		if (shadow_slots.size() > 0) begin
			r.head_valid = 1'b1;
			r.head = shadow_slots[0];
		end
		return r;
	endfunction

	// mostly back to back or short gaps, now and then a long one; none when no_idle
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// small values for ties, the two extremes, or anything in range
	function automatic int unsigned roll_key_field(int unsigned maxv);
		int unsigned r;
		r = $urandom_range(0, 5);
		if (r < 2)
			return $urandom_range(0, 3);
		if (r == 2)
			return ($urandom_range(0, 1) != 0) ? maxv : 0;
		return $urandom_range(0, maxv);
	endfunction

	// Drive one word and hold it until start && !busy at an edge.
	// start is left high on return so a zero gap never drops it for a step.
	task automatic issue_word(input cmd_t op, input entry_t e, input bit typed,
	                          input report_t typed_rep);
		int unsigned gap;
		report_t     rep;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		cmd           <= op;
		task_id       <= e.id;
		task_priority <= e.prio;
		task_burst    <= e.burst;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		rep = run_queue_op(op, e);
		reports_in_flight.push_back(typed ? typed_rep : rep);
		words_sent++;
	endtask

	// register write only once the block has drained and settled
	task automatic write_order_mode(input order_mode_t m);
		start <= 1'b0;
		while (reports_in_flight.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		shadow_mode = m;
		mode_writes[m]++;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// report check: done marks a one-cycle report, compared with the oldest owed
	always @(posedge clk) begin
		report_t want;
		if (arst_n && done) begin
			if (reports_in_flight.size() == 0) begin
				$error("report with no word outstanding: status %0h count %0d",
				       status, entry_count);
				mismatches++;
			end else begin
				want = reports_in_flight.pop_front();
				check_field("status", want.status, status);
				check_field("entry_count", want.count, entry_count);
				check_field("head_valid", want.head_valid, head_valid);
				check_field("head_task_id", want.head.id, head_task_id);
				check_field("head_priority", want.head.prio, head_priority);
				check_field("head_burst", want.head.burst, head_burst);
				reports_seen++;
			end
		end
	end

	initial begin
		entry_t      e;
		order_mode_t m;
		int unsigned ins_pct;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed plan
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				write_order_mode(plan[i].mode);
			end else begin
				for (int k = 0; k < plan[i].reps; k++) begin
					e = plan[i].key;
					e.id = e.id + 8'(k);
					issue_word(plan[i].op, e, plan[i].typed, plan[i].want);
				end
			end
		end

		// Random phases: each picks a mode and an insert share, so some
		// phases pile up against the full queue and others drain it dry.
		// Deletes mostly name an id that is queued.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0:       m = MODE_PRIO;
				1:       m = MODE_BURST;
				2:       m = MODE_LIFO;
				3:       m = MODE_FIFO;
				default: m = order_mode_t'($urandom_range(0, 3));
			endcase
			ins_pct = $urandom_range(25, 80);
			no_idle = (ph % 3 == 1);
			write_order_mode(m);
			repeat (PHASE_LEN) begin
				e.id    = 8'($urandom_range(0, 255));
				e.prio  = 8'(roll_key_field(255));
				e.burst = 16'(roll_key_field(65535));
				if (shadow_slots.size() == 0 && $urandom_range(0, 9) != 0) begin
					issue_word(CMD_INSERT, e, 1'b0, '0);
				end else if ($urandom_range(1, 100) <= ins_pct) begin
					issue_word(CMD_INSERT, e, 1'b0, '0);
				end else begin
					if (shadow_slots.size() > 0 && $urandom_range(0, 3) != 0)
						e.id = shadow_slots[$urandom_range(0, shadow_slots.size() - 1)].id;
					issue_word(CMD_DELETE, e, 1'b0, '0);
				end
			end
		end

		// drain, then wait out anything stray
		start <= 1'b0;
		while (reports_in_flight.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d words sent, %0d reports checked, %0d inserts dropped on full, %0d deletes missed",
		         words_sent, reports_seen, full_drops, delete_misses);
		$display("order mode writes: fifo %0d, prio %0d, burst %0d, lifo %0d",
		         mode_writes[MODE_FIFO], mode_writes[MODE_PRIO],
		         mode_writes[MODE_BURST], mode_writes[MODE_LIFO]);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// hang guard: far beyond the slowest legal run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
